@@ design/rfcd_pkg.sv @@
// shared types and constants of the ring fill and countdown frame generator
`default_nettype none

package rfcd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SELECT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTDOWN_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RING_ROTATIONS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RING_REVERSED  = 3'd5;

  // per-ring lit count (ring holds up to 32 leds) and active count (up to 96)
  localparam int LIT_W = 6;
  localparam int ACT_W = 7;

  // frame descriptor queue
  localparam int QDEPTH = 2;

  // arithmetic constants
  localparam logic [8:0]  FLASH_MS        = 9'd250;
  localparam logic [8:0]  FLASH_PERIOD_MS = 9'd500;
  localparam logic [16:0] Q16_ONE         = 17'd65536;
  localparam logic [23:0] LIT_ROUND       = 24'd32768;
  localparam logic [24:0] RAMP_SCALE      = 25'd510;
  localparam logic [7:0]  LEVEL_FULL      = 8'd255;
  localparam logic [5:0]  DIV_STEPS_FRAC  = 6'd16;

  typedef struct packed {
    logic        fill_mode;
    logic [23:0] fill_color;
    logic [2:0]  ring_select;
    logic [23:0] countdown_ms;
    logic [14:0] ring_rotations;
    logic [2:0]  ring_reversed;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            mask;
    logic                  all_on;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [2:0][LIT_W-1:0] lit;
  } desc_t;

  typedef struct packed {
    logic        start;
    logic [23:0] rem_init;
    logic [31:0] num;
    logic [23:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/ring_fill_countdown_frame.sv @@
// top level of the ring fill and countdown frame generator
//
// usage:
// - the request channel (in_valid_i / in_stall_o) takes one beat per frame:
//   elapsed_ms_i and progress_level_i (q16, values above 1.0 clamp)
// - the led channel (out_valid_o / out_stall_i) gives one beat per chain
//   position, TOTAL_LEDS beats per frame in order, last_led_o on the final one
// - the config port writes one register per cycle with cfg_we_i high; write
//   it only while no frame is in flight
// - throughput: one frame per TOTAL_LEDS led beats (48 by default), set by the
//   led channel moving one beat per cycle while the queue is not empty and
//   out_stall_i is low; the front end runs the one-bit-per-cycle divider
//   while counting down and up to six modulo folds for the flash phase once
//   the time is up, and runs ahead behind a two-deep queue
// - reset clears the request buffer, the queue and the output stage, and
//   loads the register defaults (progress mode, white, all rings, 10 s)
// - a stalled led beat holds; the front keeps working and the request
//   buffer keeps taking a beat until the queue fills
`default_nettype none

module ring_fill_countdown_frame #(
  parameter int OUTER_LEDS  = 24,
  parameter int MIDDLE_LEDS = 16,
  parameter int INNER_LEDS  = 8,
  parameter int TOTAL_LEDS  = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rfcd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rfcd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [31:0]                          elapsed_ms_i,
  input  logic [16:0]                          progress_level_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [5:0]                           led_index_o,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  output logic                                 last_led_o
);
  import rfcd_pkg::*;

  cfg_t     cfg_q;
  div_req_t div_req;
  div_rsp_t div_rsp;
  desc_t    push_desc, head_desc;
  logic     q_push, q_full, q_pop, q_empty;

  // register file, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_mode      <= 1'b0;
      cfg_q.fill_color     <= 24'hFFFFFF;
      cfg_q.ring_select    <= 3'd7;
      cfg_q.countdown_ms   <= 24'd10000;
      cfg_q.ring_rotations <= '0;
      cfg_q.ring_reversed  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILL_MODE:      cfg_q.fill_mode      <= cfg_wdata_i[0];
        REG_FILL_COLOR:     cfg_q.fill_color     <= cfg_wdata_i[23:0];
        REG_RING_SELECT:    cfg_q.ring_select    <= cfg_wdata_i[2:0];
        REG_COUNTDOWN_MS:   cfg_q.countdown_ms   <= cfg_wdata_i[23:0];
        REG_RING_ROTATIONS: cfg_q.ring_rotations <= cfg_wdata_i[14:0];
        REG_RING_REVERSED:  cfg_q.ring_reversed  <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify the request, run the divider, split the lit count
  rfcd_front #(
    .OUTER_LEDS (OUTER_LEDS),
    .MIDDLE_LEDS(MIDDLE_LEDS),
    .INNER_LEDS (INNER_LEDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .elapsed_ms_i    (elapsed_ms_i),
    .progress_level_i(progress_level_i),
    .cfg_i           (cfg_q),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_desc_o        (push_desc)
  );

  // divider for the countdown fraction
  rfcd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // frame descriptors waiting for the led walker
  rfcd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .desc_i (push_desc),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (head_desc)
  );

  // back: one led per beat, descriptor popped with the last led
  rfcd_back #(
    .OUTER_LEDS (OUTER_LEDS),
    .MIDDLE_LEDS(MIDDLE_LEDS),
    .INNER_LEDS (INNER_LEDS),
    .TOTAL_LEDS (TOTAL_LEDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head_desc),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .led_index_o(led_index_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .last_led_o (last_led_o)
  );

endmodule

`default_nettype wire

@@ design/rfcd_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rfcd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfcd_pkg::div_req_t req_i,
  output rfcd_pkg::div_rsp_t rsp_o
);
  import rfcd_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [23:0] dvs_q;
  logic [31:0] quo_q, quo_d;
  logic [24:0] trial;
  logic        ge;
  logic        last_step;

  assign trial     = {rem_q, num_q[31]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign last_step = busy_q && (cnt_q == 6'd1);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = last_step;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      quo_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      rem_d = ge ? 24'(trial - {1'b0, dvs_q}) : trial[23:0];
      num_d = {num_q[30:0], 1'b0};
      quo_d = {quo_q[30:0], ge};
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

@@ design/rfcd_front.sv @@
// front end: request buffer, classification, fraction math and ring split
`default_nettype none

module rfcd_front #(
  parameter int OUTER_LEDS  = 24,
  parameter int MIDDLE_LEDS = 16,
  parameter int INNER_LEDS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        elapsed_ms_i,
  input  logic [16:0]        progress_level_i,
  input  rfcd_pkg::cfg_t     cfg_i,
  output rfcd_pkg::div_req_t div_req_o,
  input  rfcd_pkg::div_rsp_t div_rsp_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rfcd_pkg::desc_t    q_desc_o
);
  import rfcd_pkg::*;

  typedef enum logic [1:0] {
    CLS_PROG,
    CLS_COUNT,
    CLS_FLASH
  } cls_e;

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_DIV   = 2'd1;
  localparam logic [1:0] F_CALC  = 2'd2;
  localparam logic [1:0] F_SPLIT = 2'd3;

  localparam logic [ACT_W-1:0] C0 = ACT_W'(OUTER_LEDS);
  localparam logic [ACT_W-1:0] C1 = ACT_W'(MIDDLE_LEDS);
  localparam logic [ACT_W-1:0] C2 = ACT_W'(INNER_LEDS);

  logic              buf_valid_q, buf_valid_d;
  logic [31:0]       buf_elapsed_q;
  logic [16:0]       buf_level_q;
  logic [1:0]        state_q, state_d;
  cls_e              cls_q, cls_d, cls_new;
  logic [16:0]       lvl_q;
  logic [ACT_W-1:0]  lit_q, lit_d;
  logic [7:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic              all_on_q, all_on_d;
  logic              accept, take, expired;
  logic [2:0]        mask;
  logic [ACT_W-1:0]  active;
  logic [31:0]       diff;
  logic [31:0]       mod_q, mod_d;
  logic              mod_small, flash_odd;
  logic [15:0]       frac;
  logic [16:0]       frac_rem;
  logic [16:0]       ramp_op, lit_op;
  logic [24:0]       ramp_prod;
  logic [23:0]       lit_prod;
  logic [7:0]        ramp;
  logic [ACT_W-1:0]  left0, left1, left2, n0, n1, n2;

  // one-entry request buffer; the port stalls while it holds a request
  assign accept     = in_valid_i && !buf_valid_q;
  assign take       = (state_q == F_IDLE) && buf_valid_q;
  assign in_stall_o = buf_valid_q;

  always_comb begin
    buf_valid_d = buf_valid_q;
    if (take) begin
      buf_valid_d = 1'b0;
    end else if (accept) begin
      buf_valid_d = 1'b1;
    end
  end

  // active rings and their led count
  assign mask   = (cfg_i.ring_select == 3'd0) ? 3'b111 : cfg_i.ring_select;
  assign active = (mask[0] ? C0 : '0) + (mask[1] ? C1 : '0) + (mask[2] ? C2 : '0);

  // classification of the buffered request
  assign expired = buf_elapsed_q >= {8'd0, cfg_i.countdown_ms};
  assign diff    = buf_elapsed_q - {8'd0, cfg_i.countdown_ms};

  always_comb begin
    if (!cfg_i.fill_mode) begin
      cls_new = CLS_PROG;
    end else if (expired) begin
      cls_new = CLS_FLASH;
    end else begin
      cls_new = CLS_COUNT;
    end
  end

  // countdown needs elapsed*2^16/duration from the divider
  always_comb begin
    div_req_o.start    = take && (cls_new == CLS_COUNT);
    div_req_o.rem_init = buf_elapsed_q[23:0];
    div_req_o.num      = '0;
    div_req_o.divisor  = cfg_i.countdown_ms;
    div_req_o.steps    = DIV_STEPS_FRAC;
  end

  // flash parity of diff/250: fold diff modulo 500 with 512 = 12 (mod 500),
  // at most six folds, then odd half periods sit in 250..499
  assign mod_small = mod_q[31:9] == '0;
  assign flash_odd = (mod_q[8:0] >= FLASH_MS) && (mod_q[8:0] < FLASH_PERIOD_MS);

  always_comb begin
    mod_d = mod_q;
    if (take) begin
      mod_d = diff;
    end else if ((state_q == F_DIV) && (cls_q == CLS_FLASH) && !mod_small) begin
      mod_d = 32'({mod_q[31:9], 3'b000}) + 32'({mod_q[31:9], 2'b00}) + 32'(mod_q[8:0]);
    end
  end

  // fraction math
  assign frac      = div_rsp_i.quo[15:0];
  assign frac_rem  = Q16_ONE - {1'b0, frac};
  assign ramp_op   = frac[15] ? frac_rem : {1'b0, frac};
  assign ramp_prod = 25'(ramp_op) * RAMP_SCALE;
  assign ramp      = ramp_prod[23:16];
  assign lit_op    = (cls_q == CLS_PROG) ? lvl_q : frac_rem;
  assign lit_prod  = 24'(lit_op) * 24'(active) + LIT_ROUND;

  always_comb begin
    lit_d    = lit_prod[16 +: ACT_W];
    red_d    = '0;
    green_d  = '0;
    blue_d   = '0;
    all_on_d = 1'b0;
    unique case (cls_q)
      CLS_PROG: begin
        red_d   = cfg_i.fill_color[23:16];
        green_d = cfg_i.fill_color[15:8];
        blue_d  = cfg_i.fill_color[7:0];
      end
      CLS_COUNT: begin
        red_d   = frac[15] ? LEVEL_FULL : ramp;
        green_d = frac[15] ? ramp : LEVEL_FULL;
      end
      CLS_FLASH: begin
        lit_d    = '0;
        red_d    = LEVEL_FULL;
        all_on_d = !flash_odd;
      end
      default: begin
        lit_d = '0;
      end
    endcase
  end

  // share the lit count out over the active rings, outer first
  always_comb begin
    left0 = ((cls_q == CLS_COUNT) && (lit_q == '0)) ? ACT_W'(1) : lit_q;
    n0    = mask[0] ? ((left0 < C0) ? left0 : C0) : '0;
    left1 = left0 - n0;
    n1    = mask[1] ? ((left1 < C1) ? left1 : C1) : '0;
    left2 = left1 - n1;
    n2    = mask[2] ? ((left2 < C2) ? left2 : C2) : '0;
  end

  always_comb begin
    q_desc_o.mask   = mask;
    q_desc_o.all_on = all_on_q;
    q_desc_o.red    = red_q;
    q_desc_o.green  = green_q;
    q_desc_o.blue   = blue_q;
    q_desc_o.lit[0] = LIT_W'(n0);
    q_desc_o.lit[1] = LIT_W'(n1);
    q_desc_o.lit[2] = LIT_W'(n2);
  end

  assign q_push_o = (state_q == F_SPLIT) && !q_full_i;

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    unique case (state_q)
      F_IDLE: begin
        if (take) begin
          cls_d   = cls_new;
          state_d = (cls_new == CLS_PROG) ? F_CALC : F_DIV;
        end
      end
      F_DIV: begin
        if ((cls_q == CLS_FLASH) ? mod_small : div_rsp_i.done) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        state_d = F_SPLIT;
      end
      F_SPLIT: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      state_q     <= F_IDLE;
      cls_q       <= CLS_PROG;
    end else begin
      buf_valid_q <= buf_valid_d;
      state_q     <= state_d;
      cls_q       <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q <= mod_d;
    if (accept) begin
      buf_elapsed_q <= elapsed_ms_i;
      buf_level_q   <= progress_level_i;
    end
    if (take) begin
      lvl_q <= (buf_level_q > Q16_ONE) ? Q16_ONE : buf_level_q;
    end
    if (state_q == F_CALC) begin
      lit_q    <= lit_d;
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      all_on_q <= all_on_d;
    end
  end

endmodule

`default_nettype wire

@@ design/rfcd_fifo.sv @@
// short frame descriptor queue between front and back
`default_nettype none

module rfcd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rfcd_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rfcd_pkg::desc_t head_o
);
  import rfcd_pkg::*;

  localparam int QPW = $clog2(QDEPTH);

  desc_t          mem_q [QDEPTH];
  logic [QPW-1:0] wr_q, rd_q;
  logic [QPW:0]   cnt_q;

  assign full_o  = cnt_q == (QPW + 1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + QPW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + QPW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

@@ design/rfcd_back.sv @@
// back end: walks the chain and emits one led color per beat
`default_nettype none

module rfcd_back #(
  parameter int OUTER_LEDS  = 24,
  parameter int MIDDLE_LEDS = 16,
  parameter int INNER_LEDS  = 8,
  parameter int TOTAL_LEDS  = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfcd_pkg::cfg_t  cfg_i,
  input  rfcd_pkg::desc_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [5:0]      led_index_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            last_led_o
);
  import rfcd_pkg::*;

  localparam int KW = $clog2(TOTAL_LEDS);
  localparam int RING_CNT [3] = '{OUTER_LEDS, MIDDLE_LEDS, INNER_LEDS};
  localparam logic [7:0] RING_BASE [3] = '{8'd0, 8'(OUTER_LEDS),
                                           8'(OUTER_LEDS + MIDDLE_LEDS)};
  localparam logic [7:0] RINGS_END = 8'(OUTER_LEDS + MIDDLE_LEDS + INNER_LEDS);

  logic [KW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;
  logic [5:0]    idx_q;
  logic [7:0]    red_q, green_q, blue_q;
  logic          last_q;
  logic          emit, last, beyond, on;
  logic [7:0]    kx;
  logic [2:0]    in_ring, hit;

  assign kx     = 8'(k_q);
  assign last   = k_q == KW'(TOTAL_LEDS - 1);
  assign beyond = kx >= RINGS_END;
  assign emit   = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o  = emit && last;

  // map each physical position back to its logical fill slot
  for (genvar r = 0; r < 3; r++) begin : g_ring
    localparam logic [5:0] CNT6 = 6'(RING_CNT[r]);
    localparam logic [7:0] TOP8 = RING_BASE[r] + 8'(RING_CNT[r]);

    logic [5:0] rot_tbl [32];
    logic [5:0] rotm, idx, idxp, slot;

    for (genvar g = 0; g < 32; g++) begin : g_rot
      localparam logic [5:0] ROT_MOD = 6'(g % RING_CNT[r]);
      assign rot_tbl[g] = ROT_MOD;
    end

    assign rotm = rot_tbl[cfg_i.ring_rotations[5*r +: 5]];
    assign idx  = 6'(kx - RING_BASE[r]);
    assign idxp = cfg_i.ring_reversed[r] ? 6'(CNT6 - 6'd1 - idx) : idx;
    assign slot = (idxp >= rotm) ? 6'(idxp - rotm) : 6'(idxp + CNT6 - rotm);

    assign in_ring[r] = (kx >= RING_BASE[r]) && (kx < TOP8);
    assign hit[r]     = slot < head_i.lit[r];
  end

  // flash lights the whole chain but disabled rings
  assign on = head_i.all_on ? (beyond || |(in_ring & head_i.mask))
                            : |(in_ring & head_i.mask & hit);

  always_comb begin
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      k_d         = last ? '0 : k_q + KW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_q   <= 6'(k_q);
      red_q   <= on ? head_i.red : 8'd0;
      green_q <= on ? head_i.green : 8'd0;
      blue_q  <= on ? head_i.blue : 8'd0;
      last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = idx_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign last_led_o  = last_q;

endmodule

`default_nettype wire

@@ design/rfcd_checker.sv @@
// port-level checks of the led channel, bound to the top level
`default_nettype none

module rfcd_checker #(
  parameter int TOTAL_LEDS = 48
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [5:0] led_index_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       last_led_i
);

  // a stalled beat stays
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("led beat dropped under stall");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      $stable({led_index_i, red_i, green_i, blue_i, last_led_i}))
    else $error("led beat changed under stall");

  // the frame end flag sits on the final chain position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_led_i |-> led_index_i == 6'(TOTAL_LEDS - 1))
    else $error("last led flag on wrong position");

  // positions advance by one and restart after the frame end
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_stall_i) ##1 out_valid_i |->
      led_index_i == ($past(last_led_i) ? 6'd0 : 6'($past(led_index_i) + 6'd1)))
    else $error("led positions out of order");

endmodule

bind ring_fill_countdown_frame rfcd_checker #(
  .TOTAL_LEDS(TOTAL_LEDS)
) u_rfcd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .led_index_i(led_index_o),
  .red_i      (red_o),
  .green_i    (green_o),
  .blue_i     (blue_o),
  .last_led_i (last_led_o)
);

`default_nettype wire
